>>> src/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// Used by the front decoder, the item queue, the bus engine and the top level.
package i2cm_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register index taken from paddr[2].
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_TAIL        = 1'b1;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;
    localparam logic [7:0] TAIL_RESET        = 8'd6;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_ADDR  = 3'd3,
        CMD_BYTE  = 3'd4,
        CMD_RECV  = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_HIGH,
        PH_ST_LOW,
        PH_SP_WAIT,
        PH_SP_END,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        SG_SEND_DATA,
        SG_RECV_ACK,
        SG_RECV_DATA,
        SG_SEND_ACK
    } t_stage;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda;
        logic       scl;
    } t_item;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] tail_ticks;
    } t_cfg;

    typedef struct packed {
        logic       bus_error;
        logic [7:0] received_byte;
        logic       done_res;
        logic       ready_res;
        logic       sda_release;
        logic       scl_release;
    } t_result;

    typedef struct packed {
        t_phase     phase;
        t_stage     stage;
        logic [3:0] bits_left;
        logic [7:0] shift_reg;
        logic [7:0] tick_count;
        logic       error_flag;
        logic [7:0] rx_hold;
        logic       ack_choice;
        logic       scl_drv;
        logic       sda_drv;
        logic       done;
    } t_eng;

endpackage

>>> src/i2cm_front.sv
// Front part: unpacks an incoming stream item and classifies its command.
// Depends on i2cm_pkg; feeds i2cm_queue.
module i2cm_front import i2cm_pkg::*; (
    input  logic                  i_tvalid,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic                  i_space,
    output logic                  o_tready,
    output logic                  o_push,
    output t_item                 o_item
);

    logic [2:0] w_raw_cmd;
    logic [7:0] w_data;
    logic       w_read_mode;

    assign w_raw_cmd   = i_tdata[2:0];
    assign w_data      = i_tdata[10:3];
    assign w_read_mode = i_tdata[11];

    assign o_tready = i_space;
    assign o_push   = i_tvalid & i_space;

    always_comb begin
        o_item.send_ack = i_tdata[12];
        o_item.sda      = i_tdata[13];
        o_item.scl      = i_tdata[14];
        o_item.tx_byte  = w_data;
        // Codes without meaning are treated as no command.
        unique case (w_raw_cmd)
            CMD_START, CMD_STOP, CMD_BYTE, CMD_RECV: begin
                o_item.cmd = t_cmd'(w_raw_cmd);
            end
            CMD_ADDR: begin
                o_item.cmd     = CMD_ADDR;
                o_item.tx_byte = w_data | {7'd0, w_read_mode};
            end
            default: begin
                o_item.cmd = CMD_NONE;
            end
        endcase
    end

endmodule

>>> src/i2cm_queue.sv
// Two-entry item queue between the front decoder and the bus engine.
// Depends on i2cm_pkg for the item type.
module i2cm_queue import i2cm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_space,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> src/i2cm_engine.sv
// Back part: the I2C bus sequencer, advanced by one item per tick, with its
// registered result. Depends on i2cm_pkg; takes items from i2cm_queue.
module i2cm_engine import i2cm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    t_eng    r_st;
    t_eng    n_st;
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;
    logic    w_take;

    function automatic logic bit_drive(t_eng s);
        logic d;
        unique case (s.stage)
            SG_SEND_DATA: d = s.shift_reg[7];
            SG_SEND_ACK:  d = ~s.ack_choice;
            default:      d = 1'b1;
        endcase
        return d;
    endfunction

    function automatic t_eng begin_bits(t_eng s, t_stage sg, logic [3:0] count);
        t_eng r;
        r            = s;
        r.stage      = sg;
        r.bits_left  = count;
        r.scl_drv    = 1'b0;
        r.sda_drv    = bit_drive(r);
        r.phase      = PH_BIT_LOW;
        r.tick_count = 8'd1;
        return r;
    endfunction

    function automatic t_eng begin_stop(t_eng s);
        t_eng r;
        r            = s;
        r.sda_drv    = 1'b0;
        r.scl_drv    = 1'b1;
        r.phase      = PH_SP_WAIT;
        r.tick_count = 8'd0;
        return r;
    endfunction

    function automatic t_eng finish(t_eng s);
        t_eng r;
        r            = s;
        r.phase      = PH_IDLE;
        r.tick_count = 8'd0;
        r.done       = 1'b1;
        return r;
    endfunction

    function automatic t_eng end_tail(t_eng s);
        t_eng r;
        r = s;
        unique case (s.stage)
            SG_SEND_DATA: r = begin_bits(s, SG_RECV_ACK, 4'd1);
            SG_RECV_ACK: begin
                // A high acknowledge is a NACK: flag it and release the bus.
                if (s.shift_reg[0]) begin
                    r.error_flag = 1'b1;
                    r = begin_stop(r);
                end else begin
                    r = finish(s);
                end
            end
            SG_RECV_DATA: begin
                r.rx_hold = s.shift_reg;
                r = begin_bits(r, SG_SEND_ACK, 4'd1);
            end
            SG_SEND_ACK: begin
                r.sda_drv = 1'b1;
                r = finish(r);
            end
        endcase
        return r;
    endfunction

    function automatic t_eng enter_tail(t_eng s, logic [7:0] tail);
        t_eng r;
        r         = s;
        r.scl_drv = 1'b0;
        if (tail == 8'd0) begin
            r = end_tail(r);
        end else begin
            r.phase      = PH_TAIL;
            r.tick_count = 8'd1;
        end
        return r;
    endfunction

    logic [7:0] w_hp;
    logic [7:0] w_limit;

    assign w_hp    = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign w_limit = (r_st.phase == PH_TAIL) ? i_cfg.tail_ticks : w_hp;

    always_comb begin
        n_st      = r_st;
        n_st.done = 1'b0;
        if (r_st.phase == PH_IDLE) begin
            unique case (i_item.cmd)
                CMD_START: begin
                    n_st.scl_drv    = 1'b1;
                    n_st.phase      = PH_ST_HIGH;
                    n_st.tick_count = 8'd1;
                end
                CMD_STOP: n_st = begin_stop(n_st);
                CMD_ADDR, CMD_BYTE: begin
                    n_st.shift_reg = i_item.tx_byte;
                    n_st = begin_bits(n_st, SG_SEND_DATA, 4'd8);
                end
                CMD_RECV: begin
                    n_st.ack_choice = i_item.send_ack;
                    n_st.shift_reg  = 8'd0;
                    n_st = begin_bits(n_st, SG_RECV_DATA, 4'd8);
                end
                default: begin
                end
            endcase
        end else if (r_st.phase == PH_SP_WAIT || r_st.phase == PH_BIT_HIGH) begin
            // High halves only count ticks while SCL reads high (stretching).
            if (i_item.scl) begin
                n_st.tick_count = r_st.tick_count + 8'd1;
            end
            if (n_st.tick_count >= w_hp) begin
                if (r_st.phase == PH_SP_WAIT) begin
                    n_st.sda_drv    = 1'b1;
                    n_st.phase      = PH_SP_END;
                    n_st.tick_count = 8'd1;
                end else begin
                    n_st.shift_reg = {r_st.shift_reg[6:0], i_item.sda};
                    n_st.bits_left = r_st.bits_left - 4'd1;
                    n_st.scl_drv   = 1'b0;
                    if (n_st.bits_left != 4'd0) begin
                        n_st.sda_drv    = bit_drive(n_st);
                        n_st.phase      = PH_BIT_LOW;
                        n_st.tick_count = 8'd1;
                    end else begin
                        n_st = enter_tail(n_st, i_cfg.tail_ticks);
                    end
                end
            end
        end else if (r_st.tick_count < w_limit) begin
            n_st.tick_count = r_st.tick_count + 8'd1;
        end else begin
            unique case (r_st.phase)
                PH_ST_HIGH: begin
                    n_st.sda_drv    = 1'b0;
                    n_st.phase      = PH_ST_LOW;
                    n_st.tick_count = 8'd1;
                end
                PH_ST_LOW: begin
                    n_st.scl_drv = 1'b0;
                    n_st.sda_drv = 1'b1;
                    n_st = finish(n_st);
                end
                PH_SP_END: n_st = finish(n_st);
                PH_BIT_LOW: begin
                    n_st.scl_drv    = 1'b1;
                    n_st.phase      = PH_BIT_HIGH;
                    n_st.tick_count = 8'd0;
                end
                PH_TAIL: n_st = end_tail(n_st);
                default: begin
                    n_st.phase      = PH_IDLE;
                    n_st.tick_count = 8'd0;
                end
            endcase
        end
    end

    always_comb begin
        n_result.scl_release   = n_st.scl_drv;
        n_result.sda_release   = n_st.sda_drv;
        n_result.ready_res     = (n_st.phase == PH_IDLE);
        n_result.done_res      = n_st.done;
        n_result.received_byte = n_st.rx_hold;
        n_result.bus_error     = n_st.error_flag;
    end

    // The output register frees itself in the cycle its result is taken.
    assign w_take      = i_valid & (~r_out_valid | i_out_ready);
    assign o_pop       = w_take;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase      <= PH_IDLE;
            r_st.stage      <= SG_SEND_DATA;
            r_st.bits_left  <= 4'd0;
            r_st.shift_reg  <= 8'd0;
            r_st.tick_count <= 8'd0;
            r_st.error_flag <= 1'b0;
            r_st.rx_hold    <= 8'd0;
            r_st.ack_choice <= 1'b0;
            r_st.scl_drv    <= 1'b1;
            r_st.sda_drv    <= 1'b1;
            r_st.done       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_take) begin
                r_st <= n_st;
            end
            r_out_valid <= w_take | (r_out_valid & ~i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

endmodule

>>> src/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: configuration registers and the
// front decoder, item queue and bus engine. Depends on i2cm_pkg and all src modules.
//
//  Channel   Direction  Handshake               Contents
//  s_axis    in         tvalid/tready           one bus tick: command and line samples
//  m_axis    out        tvalid/tready           one result per tick: drives and status
//  APB       in         psel/penable/pready     half_period_ticks (0x0), tail_ticks (0x4)
//
// One item is taken every clock cycle while the queue has space; the bus engine
// updates its state once per item. A result passes through the queue and then the
// engine's output register. Reset is synchronous and needs no clearing pass.
// When m_axis stalls, the queue absorbs up to two items before s_axis_tready falls.
module i2c_master_byte_engine import i2cm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] command, [10:3] data_byte, [11] read_mode, [12] send_ack,
    // [13] sda_sample, [14] scl_sample, [15] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] scl_release, [1] sda_release, [2] ready_res, [3] done_res,
    // [11:4] received_byte, [12] bus_error, [15:13] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_cfg    r_cfg;
    logic    w_cfg_wr;
    logic    w_reg_idx;
    logic    w_space;
    logic    w_push;
    t_item   w_in_item;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_pop;
    t_result w_result;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_PERIOD_RESET;
            r_cfg.tail_ticks        <= TAIL_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_HALF_PERIOD: r_cfg.half_period_ticks <= pwdata[7:0];
                REG_TAIL:        r_cfg.tail_ticks        <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_HALF_PERIOD: prdata = {24'd0, r_cfg.half_period_ticks};
            REG_TAIL:        prdata = {24'd0, r_cfg.tail_ticks};
        endcase
    end

    i2cm_front u_front (
        .i_tvalid (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .i_space  (w_space),
        .o_tready (s_axis_tready),
        .o_push   (w_push),
        .o_item   (w_in_item)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_space (w_space),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    i2cm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {3'd0, w_result};

    // A finishing command always leaves the engine idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[2])
        else $error("done_res without ready_res");

    // The bus error flag, once reported, stays set until reset.
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[12]) |=> m_axis_tdata[12])
        else $error("bus_error cleared without reset");

    // The queue only fills up behind a stalled output.
    a_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output was flowing");

endmodule

>>> tb/i2c_master_byte_engine_tb.sv
// Self-checking testbench for the I2C master byte engine: drives bus ticks on the
// input stream, predicts every result item and checks the output stream.
// Depends on i2cm_pkg and the RTL under src.
module i2c_master_byte_engine_tb import i2cm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Codes 6 and 7 are not commands; the engine ignores them.
    localparam logic [2:0] CMD_RESERVED_LO = 3'd6;
    localparam logic [2:0] CMD_RESERVED_HI = 3'd7;
    localparam int         HOLD_CYCLES     = 64;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [2:0] command, [10:3] data_byte, [11] read_mode, [12] send_ack,
    // [13] sda_sample, [14] scl_sample, [15] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] scl_release, [1] sda_release, [2] ready_res, [3] done_res,
    // [11:4] received_byte, [12] bus_error, [15:13] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    i2c_master_byte_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Bus engine as the testbench sees it, advanced once per accepted item.
    logic [7:0] half_cfg   = HALF_PERIOD_RESET;
    logic [7:0] tail_cfg   = TAIL_RESET;
    t_phase     bus_phase  = PH_IDLE;
    t_stage     bus_stage  = SG_SEND_DATA;
    logic [3:0] bits_togo  = '0;
    logic [7:0] shifter    = '0;
    logic [7:0] tick_ctr   = '0;
    logic       err_seen   = 1'b0;
    logic [7:0] rx_latched = '0;
    logic       ack_pick   = 1'b0;
    logic       scl_out    = 1'b1;
    logic       sda_out    = 1'b1;
    logic       done_pulse = 1'b0;

    t_result bus_outputs_due[$];

    int  fail_count      = 0;
    int  ticks_sent      = 0;
    int  commands_issued = 0;
    int  nacks_seen      = 0;
    int  results_checked = 0;
    int  input_stalls    = 0;
    int  stretch_pct     = 10;
    int  burst_left      = 0;
    bit  steady          = 1'b0;
    bit  hold_req        = 1'b0;

    function automatic logic [7:0] half_len();
        return (half_cfg == 8'd0) ? 8'd1 : half_cfg;
    endfunction

    function automatic logic level_for_bit();
        case (bus_stage)
            SG_SEND_DATA: return shifter[7];
            SG_SEND_ACK:  return ~ack_pick;
            default:      return 1'b1;
        endcase
    endfunction

    function automatic void open_bits(t_stage sg, logic [3:0] n);
        bus_stage = sg;
        bits_togo = n;
        scl_out   = 1'b0;
        sda_out   = level_for_bit();
        bus_phase = PH_BIT_LOW;
        tick_ctr  = 8'd1;
    endfunction

    function automatic void open_stop();
        sda_out   = 1'b0;
        scl_out   = 1'b1;
        bus_phase = PH_SP_WAIT;
        tick_ctr  = 8'd0;
    endfunction

    function automatic void close_cmd();
        bus_phase  = PH_IDLE;
        tick_ctr   = 8'd0;
        done_pulse = 1'b1;
    endfunction

    function automatic void tail_over();
        case (bus_stage)
            SG_SEND_DATA: open_bits(SG_RECV_ACK, 4'd1);
            SG_RECV_ACK: begin
                // A high acknowledge is a NACK: flag it and issue a stop on our own.
                if (shifter[0]) begin
                    err_seen = 1'b1;
                    nacks_seen++;
                    open_stop();
                end else begin
                    close_cmd();
                end
            end
            SG_RECV_DATA: begin
                rx_latched = shifter;
                open_bits(SG_SEND_ACK, 4'd1);
            end
            default: begin
                sda_out = 1'b1;
                close_cmd();
            end
        endcase
    endfunction

    function automatic void enter_tail();
        scl_out = 1'b0;
        if (tail_cfg == 8'd0) begin
            tail_over();
        end else begin
            bus_phase = PH_TAIL;
            tick_ctr  = 8'd1;
        end
    endfunction

    function automatic void take_cmd(logic [2:0] cmd, logic [7:0] data, logic rd, logic ack);
        case (cmd)
            CMD_START: begin
                scl_out   = 1'b1;
                bus_phase = PH_ST_HIGH;
                tick_ctr  = 8'd1;
            end
            CMD_STOP: open_stop();
            CMD_ADDR, CMD_BYTE: begin
                shifter = data;
                if (cmd == CMD_ADDR && rd)
                    shifter[0] = 1'b1;
                open_bits(SG_SEND_DATA, 4'd8);
            end
            CMD_RECV: begin
                ack_pick = ack;
                shifter  = 8'd0;
                open_bits(SG_RECV_DATA, 4'd8);
            end
            default: ;
        endcase
    endfunction

    function automatic void clock_tick(logic sda, logic scl);
        logic [7:0] hp;
        logic [7:0] limit;
        hp = half_len();
        // High halves only count ticks while SCL reads high (clock stretching).
        if (bus_phase == PH_SP_WAIT || bus_phase == PH_BIT_HIGH) begin
            if (scl)
                tick_ctr++;
            if (tick_ctr < hp)
                return;
            if (bus_phase == PH_SP_WAIT) begin
                sda_out   = 1'b1;
                bus_phase = PH_SP_END;
                tick_ctr  = 8'd1;
                return;
            end
            shifter   = {shifter[6:0], sda};
            bits_togo = bits_togo - 4'd1;
            scl_out   = 1'b0;
            if (bits_togo != 4'd0) begin
                sda_out   = level_for_bit();
                bus_phase = PH_BIT_LOW;
                tick_ctr  = 8'd1;
            end else begin
                enter_tail();
            end
            return;
        end
        limit = (bus_phase == PH_TAIL) ? tail_cfg : hp;
        if (tick_ctr < limit) begin
            tick_ctr++;
            return;
        end
        case (bus_phase)
            PH_ST_HIGH: begin
                sda_out   = 1'b0;
                bus_phase = PH_ST_LOW;
                tick_ctr  = 8'd1;
            end
            PH_ST_LOW: begin
                scl_out = 1'b0;
                sda_out = 1'b1;
                close_cmd();
            end
            PH_SP_END: close_cmd();
            PH_BIT_LOW: begin
                scl_out   = 1'b1;
                bus_phase = PH_BIT_HIGH;
                tick_ctr  = 8'd0;
            end
            PH_TAIL: tail_over();
            default: begin
                bus_phase = PH_IDLE;
                tick_ctr  = 8'd0;
            end
        endcase
    endfunction

    function automatic t_result predict_bus_tick(logic [IN_TDATA_W-1:0] w);
        t_result r;
        done_pulse = 1'b0;
        if (bus_phase == PH_IDLE)
            take_cmd(w[2:0], w[10:3], w[11], w[12]);
        else
            clock_tick(w[13], w[14]);
        r.scl_release   = scl_out;
        r.sda_release   = sda_out;
        r.ready_res     = (bus_phase == PH_IDLE);
        r.done_res      = done_pulse;
        r.received_byte = rx_latched;
        r.bus_error     = err_seen;
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] tick_word(logic [2:0] cmd, logic [7:0] data,
                                                        logic rd, logic ack,
                                                        logic sda, logic scl);
        return {1'b0, scl, sda, ack, rd, data, cmd};
    endfunction

    function automatic logic line_scl();
        return ($urandom_range(0, 99) >= stretch_pct);
    endfunction

    // Output side: compare every accepted result item with the oldest prediction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[12:0]);
            if (bus_outputs_due.size() == 0) begin
                $error("result item with no prediction waiting: %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = bus_outputs_due.pop_front();
                results_checked++;
                if (got.scl_release !== want.scl_release) begin
                    $error("scl_release: expected %0d, got %0d", want.scl_release,
                           got.scl_release);
                    fail_count++;
                end
                if (got.sda_release !== want.sda_release) begin
                    $error("sda_release: expected %0d, got %0d", want.sda_release,
                           got.sda_release);
                    fail_count++;
                end
                if (got.ready_res !== want.ready_res) begin
                    $error("ready_res: expected %0d, got %0d", want.ready_res, got.ready_res);
                    fail_count++;
                end
                if (got.done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                    fail_count++;
                end
                if (got.received_byte !== want.received_byte) begin
                    $error("received_byte: expected %h, got %h", want.received_byte,
                           got.received_byte);
                    fail_count++;
                end
                if (got.bus_error !== want.bus_error) begin
                    $error("bus_error: expected %0d, got %0d", want.bus_error, got.bus_error);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: stretches of steady, patchy, mostly ready or mostly stalled
    // readiness, and one long hold-off when the test asks for it.
    initial begin
        int seg;
        int mode;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                seg  = $urandom_range(4, 40);
                mode = $urandom_range(0, 3);
                for (int k = 0; k < seg && !hold_req; k++) begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_item(input logic [IN_TDATA_W-1:0] w);
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            input_stalls++;
            @(posedge i_clk);
        end
        bus_outputs_due.push_back(predict_bus_tick(w));
        ticks_sent++;
    endtask

    task automatic pause_sender(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Sends one tick, then, if not steady, perhaps a gap when the burst runs out.
    task automatic tick(input logic [IN_TDATA_W-1:0] w);
        send_item(w);
        if (!steady) begin
            if (burst_left == 0) begin
                pause_sender($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Issues a command on an idle engine and keeps ticking until it is idle again.
    // Commands offered while busy are random and must be ignored.
    task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] data, input logic rd,
                           input logic ack, input logic nack);
        logic sda;
        if (cmd >= CMD_START && cmd <= CMD_RECV)
            commands_issued++;
        tick(tick_word(cmd, data, rd, ack, 1'($urandom_range(0, 1)), line_scl()));
        while (bus_phase != PH_IDLE) begin
            sda = (bus_stage == SG_RECV_ACK) ? nack : 1'($urandom_range(0, 1));
            tick(tick_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sda,
                           line_scl()));
        end
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (bus_outputs_due.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic apb_write_check(input logic idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {24'd0, value}) begin
            $error("register %0d readback: expected %h, got %h", idx, value, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [7:0] hp, input logic [7:0] tail);
        wait_results_drained();
        apb_write_check(REG_HALF_PERIOD, hp);
        apb_write_check(REG_TAIL, tail);
        half_cfg = hp;
        tail_cfg = tail;
    endtask

    // Start, address, one to three data bytes in the direction the address asks, stop.
    task automatic transaction();
        logic rd;
        int   n;
        rd = 1'($urandom_range(0, 1));
        n  = $urandom_range(1, 3);
        run_cmd(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
        run_cmd(CMD_ADDR, {7'($urandom_range(0, 127)), 1'b0}, rd, 1'($urandom_range(0, 1)),
                $urandom_range(0, 9) == 0);
        repeat (n) begin
            if (rd)
                run_cmd(CMD_RECV, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'b0);
            else
                run_cmd(CMD_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), $urandom_range(0, 6) == 0);
        end
        run_cmd(CMD_STOP, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_commands_at_reset_timing();
        run_cmd(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(CMD_RESERVED_LO, 8'hff, 1'b1, 1'b1, 1'b0);
        run_cmd(CMD_RESERVED_HI, 8'h55, 1'b0, 1'b1, 1'b0);
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(CMD_ADDR, 8'ha0, 1'b1, 1'b0, 1'b0);
        run_cmd(CMD_RECV, 8'hff, 1'b0, 1'b1, 1'b0);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // A NACK raises the sticky error and a stop follows without being asked for.
    task automatic test_nack_and_sticky_error();
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(CMD_BYTE, 8'h5a, 1'b1, 1'b0, 1'b1);
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_timing_extremes();
        // Zero half period behaves as one tick, zero tail skips the tail.
        set_timing(8'd0, 8'd0);
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(CMD_BYTE, 8'hc3, 1'b0, 1'b0, 1'b0);
        run_cmd(CMD_RECV, 8'h00, 1'b0, 1'b1, 1'b0);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
        set_timing(8'd255, 8'd255);
        run_cmd(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(CMD_RESERVED_HI, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_clock_stretching();
        set_timing(8'd2, 8'd1);
        stretch_pct = 60;
        run_cmd(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
        run_cmd(CMD_RECV, 8'h00, 1'b0, 1'b1, 1'b0);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
        stretch_pct = 10;
    endtask

    // The receiver holds off while the sender keeps offering items back to back.
    task automatic test_backpressure();
        steady   = 1'b1;
        hold_req = 1'b1;
        transaction();
        steady = 1'b0;
        wait_results_drained();
        pause_sender($urandom_range(1, 8));
    endtask

    task automatic random_traffic(input logic [7:0] hp, input logic [7:0] tail, input int n);
        int start_ticks;
        set_timing(hp, tail);
        start_ticks = ticks_sent;
        while (ticks_sent - start_ticks < n) begin
            if ($urandom_range(0, 4) != 0)
                transaction();
            else
                run_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_commands_at_reset_timing();
        test_nack_and_sticky_error();
        test_timing_extremes();
        test_clock_stretching();
        test_backpressure();
        random_traffic(8'd1, 8'd0, 50);
        random_traffic(8'($urandom_range(2, 4)), 8'($urandom_range(0, 3)), 50);
        random_traffic(8'($urandom_range(1, 3)), 8'($urandom_range(1, 8)), 50);
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d bus ticks, %0d commands and %0d NACKs; %0d result items checked.",
                 ticks_sent, commands_issued, nacks_seen, results_checked);
        $display("Input side stalled for %0d cycles; %0d mismatches found.",
                 input_stalls, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Run timed out with %0d result items still awaited.",
                 bus_outputs_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
